// ----- rtl/tccw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cell writer package
// Shared widths, geometry constants, command codes and sequencer states.
// ----------------------------------------------------------------------------
package tccw_pkg;

   // Screen geometry.
   localparam int COLS  = 80;
   localparam int ROWS  = 25;
   localparam int CELLS = COLS * ROWS;

   // Field widths.
   localparam int CMD_W     = 2;
   localparam int CHAR_W    = 8;
   localparam int ATTR_W    = 8;
   localparam int CELL_W    = CHAR_W + ATTR_W;
   localparam int CELL_AW   = 11;
   localparam int COL_W     = 7;
   localparam int ROW_W     = 5;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   // Character code that starts a new line.
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

   // Command codes carried on the request sideband.
   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE_CHAR = 2'd0,
      CMD_BACKSPACE  = 2'd1,
      CMD_CLEAR      = 2'd2,
      CMD_READ       = 2'd3
   } cmd_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_WRITE,
      ST_SCR_RD,
      ST_SCR_WR,
      ST_SCR_CLR,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/tccw_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/text_console_cell_writer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cell writer
// Character-cell text store with a cursor, driven by a small command stream.
// ----------------------------------------------------------------------------
// Usage: each request word carries a command on req_tuser (write char,
// backspace, clear screen, read cell) with the character, attribute and cell
// index on req_tdata. Every request yields exactly one response word holding
// the read data, the cursor position after the command and a scroll flag.
// One command is worked on at a time; req_tready is high only while the
// sequencer is idle. Write char without wrap or scroll, backspace and an
// out-of-range read go from EXEC to DONE, which loads the response register
// once it is free; a read or a wrapped write passes READ or WRITE first.
// The store sits in one RAM with one write and one registered read port,
// and that port pair sets the long cases: a scroll copies each of the
// COLS*(ROWS-1) cells with a read state and a write state, then clears the
// bottom row, and a wrapped character is then stored through WRITE. Clear
// screen walks the whole store. After reset the same clearing pass runs
// before the first request is taken. A finished response waits in its output
// register while the receiver stalls, and the next request can already be
// accepted then.
// ----------------------------------------------------------------------------
module text_console_cell_writer_core (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] char_code, [15:8] attribute, [26:16] cell_index, [31:27] zero
   input  logic [tccw_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [1:0] cmd
   input  logic [tccw_pkg::CMD_W-1:0]         req_tuser,
   // Response channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [15:0] read_data, [22:16] cursor_col, [27:23] cursor_row,
   // [28] scrolled, [31:29] zero
   output logic [tccw_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   import tccw_pkg::*;

   // Sequencer and item registers.
   state_type            state_ff, state_in;
   logic                 init_ff, init_in;
   logic [CELL_AW-1:0]   ptr_ff, ptr_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   cmd_type              cmd_ff, cmd_in;
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic [ATTR_W-1:0]    attr_ff, attr_in;
   logic [CELL_AW-1:0]   idx_ff, idx_in;
   logic                 scrolled_ff, scrolled_in;
   logic                 wrap_ff, wrap_in;
   logic [CELL_W-1:0]    rdata_ff, rdata_in;

   // Response register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [COL_W-1:0]     rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]     rsp_row_ff, rsp_row_in;
   logic                 rsp_scrolled_ff, rsp_scrolled_in;

   // RAM port signals.
   logic                 ram_we;
   logic [CELL_AW-1:0]   ram_waddr;
   logic [CELL_W-1:0]    ram_wdata;
   logic [CELL_AW-1:0]   ram_raddr;
   logic [CELL_W-1:0]    ram_rdata;

   // Shared address arithmetic and decodes.
   logic [CELL_AW-1:0]   row_base;
   logic                 at_bottom;
   logic                 past_last_col;
   logic                 is_newline;
   logic                 idx_in_range;
   logic                 copy_last;
   logic                 sweep_last;
   logic                 rsp_free;

   assign row_base      = CELL_AW'(row_ff) * CELL_AW'(COLS);
   assign at_bottom     = (row_ff == ROW_W'(ROWS - 1));
   assign past_last_col = (col_ff >= COL_W'(COLS));
   assign is_newline    = (char_ff == NEWLINE_CODE);
   assign idx_in_range  = (idx_ff < CELL_AW'(CELLS));
   assign copy_last     = (ptr_ff == CELL_AW'(CELLS - COLS - 1));
   assign sweep_last    = (ptr_ff == CELL_AW'(CELLS - 1));
   assign rsp_free      = !rsp_valid_ff || rsp_tready;

   // Text store.
   tccw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sweep_last) begin
               state_in = init_ff ? ST_IDLE : ST_DONE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (cmd_ff)
               CMD_WRITE_CHAR: begin
                  if (is_newline || past_last_col) begin
                     if (at_bottom) begin
                        state_in = ST_SCR_RD;
                     end else begin
                        state_in = is_newline ? ST_DONE : ST_WRITE;
                     end
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               CMD_BACKSPACE: state_in = ST_DONE;
               CMD_CLEAR:     state_in = ST_CLEAR;
               CMD_READ:      state_in = idx_in_range ? ST_READ : ST_DONE;
               default:       state_in = ST_DONE;
            endcase
         end
         ST_READ:   state_in = ST_DONE;
         ST_WRITE:  state_in = ST_DONE;
         ST_SCR_RD: state_in = ST_SCR_WR;
         ST_SCR_WR: state_in = copy_last ? ST_SCR_CLR : ST_SCR_RD;
         ST_SCR_CLR: begin
            if (sweep_last) begin
               state_in = wrap_ff ? ST_WRITE : ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, store port and response control for each state.
   always_comb begin
      init_in         = init_ff;
      ptr_in          = ptr_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      cmd_in          = cmd_ff;
      char_in         = char_ff;
      attr_in         = attr_ff;
      idx_in          = idx_ff;
      scrolled_in     = scrolled_ff;
      wrap_in         = wrap_ff;
      rdata_in        = rdata_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;
      rsp_col_in      = rsp_col_ff;
      rsp_row_in      = rsp_row_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      ram_we          = 1'b0;
      ram_waddr       = ptr_ff;
      ram_wdata       = '0;
      ram_raddr       = ptr_ff + CELL_AW'(COLS);

      unique case (state_ff)
         // Sweep zeros through the whole store.
         ST_CLEAR: begin
            ram_we = 1'b1;
            if (sweep_last) begin
               ptr_in  = '0;
               init_in = 1'b0;
            end else begin
               ptr_in = ptr_ff + CELL_AW'(1);
            end
         end
         // Capture a new request word.
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in      = cmd_type'(req_tuser);
               char_in     = req_tdata[CHAR_W-1:0];
               attr_in     = req_tdata[CELL_W-1:CHAR_W];
               idx_in      = req_tdata[CELL_W+CELL_AW-1:CELL_W];
               scrolled_in = 1'b0;
               wrap_in     = 1'b0;
               rdata_in    = '0;
            end
         end
         // Decode the command and update the cursor.
         ST_EXEC: begin
            unique case (cmd_ff)
               CMD_WRITE_CHAR: begin
                  if (is_newline || past_last_col) begin
                     // New line; a wrapped character lands at column 0.
                     col_in  = is_newline ? COL_W'(0) : COL_W'(1);
                     wrap_in = !is_newline;
                     if (at_bottom) begin
                        scrolled_in = 1'b1;
                        ptr_in      = '0;
                     end else begin
                        row_in = row_ff + ROW_W'(1);
                     end
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = row_base + CELL_AW'(col_ff);
                     ram_wdata = {attr_ff, char_ff};
                     col_in    = col_ff + COL_W'(1);
                  end
               end
               CMD_BACKSPACE: begin
                  if (col_ff != '0) begin
                     ram_we    = 1'b1;
                     ram_waddr = row_base + CELL_AW'(col_ff - COL_W'(1));
                     col_in    = col_ff - COL_W'(1);
                  end
               end
               CMD_CLEAR: begin
                  col_in = '0;
                  row_in = '0;
                  ptr_in = '0;
               end
               CMD_READ: begin
                  ram_raddr = idx_ff;
               end
               default: begin
                  ram_we = 1'b0;
               end
            endcase
         end
         // Registered read data arrives.
         ST_READ: begin
            rdata_in = ram_rdata;
         end
         // Store a wrapped character at the start of the current row.
         ST_WRITE: begin
            ram_we    = 1'b1;
            ram_waddr = row_base;
            ram_wdata = {attr_ff, char_ff};
         end
         // Scroll copy: read one row down, then write it back one row up.
         ST_SCR_RD: begin
            ram_raddr = ptr_ff + CELL_AW'(COLS);
         end
         ST_SCR_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            ptr_in    = ptr_ff + CELL_AW'(1);
         end
         // Clear the bottom row after the copy.
         ST_SCR_CLR: begin
            ram_we = 1'b1;
            ptr_in = sweep_last ? CELL_AW'(0) : ptr_ff + CELL_AW'(1);
         end
         // Hand the result to the response register.
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_data_in     = rdata_ff;
               rsp_col_in      = col_ff;
               rsp_row_in      = row_ff;
               rsp_scrolled_in = scrolled_ff;
            end
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         init_ff      <= 1'b1;
         ptr_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         ptr_ff       <= ptr_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      char_ff         <= char_in;
      attr_ff         <= attr_in;
      idx_ff          <= idx_in;
      scrolled_ff     <= scrolled_in;
      wrap_ff         <= wrap_in;
      rdata_ff        <= rdata_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_col_ff      <= rsp_col_in;
      rsp_row_ff      <= rsp_row_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

   // Port outputs.
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {
      {(RSP_DATA_W - CELL_W - COL_W - ROW_W - 1){1'b0}},
      rsp_scrolled_ff, rsp_row_ff, rsp_col_ff, rsp_data_ff
   };

   // The cursor row never leaves the screen.
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff < ROW_W'(ROWS))
      else $error("cursor row beyond the bottom row");

   // The cursor column never goes past one beyond the last column.
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= COL_W'(COLS))
      else $error("cursor column out of range");

   // Every store write lands inside the store.
   a_waddr_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (ram_waddr < CELL_AW'(CELLS)))
      else $error("store write address out of range");

   // A scrolled response always leaves the cursor on the bottom row.
   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_scrolled_ff) |-> (rsp_row_ff == ROW_W'(ROWS - 1)))
      else $error("scroll reported with cursor off the bottom row");

   // No request is taken while the start-up clearing pass runs.
   a_init_blocks: assert property (@(posedge clock) disable iff (reset)
      init_ff |-> !req_tready)
      else $error("request accepted during start-up clear");

endmodule
